// ----- rtl/core/dcci_pkg.sv -----
`timescale 1ns / 1ps

package dcci_pkg;

  localparam int unsigned FactorW = 16;
  localparam int unsigned FarW    = 32;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned FracW   = 4;
  localparam int unsigned CueSh   = 12;
  localparam int unsigned ScaleW  = FactorW + 1;
  localparam int unsigned ProdW   = ScaleW + FarW;
  localparam int unsigned SrcW    = ChanW + FracW;
  localparam int unsigned DiffW   = 16;
  localparam int unsigned MulW    = FactorW + DiffW;
  localparam int unsigned SumW    = MulW - CueSh + 1;

  localparam logic signed [ScaleW-1:0] CueOne = ScaleW'(17'sd4096);
  localparam logic signed [DiffW-1:0]  DiffMax = 16'sh7FFF;
  localparam logic signed [DiffW-1:0]  DiffMin = 16'sh8000;
  localparam logic [ChanW-1:0]         ChanMax = 8'hFF;

  typedef enum logic [1:0] {
    RegGlobalFactor = 2'd0,
    RegGlobalRed    = 2'd1,
    RegGlobalGreen  = 2'd2,
    RegGlobalBlue   = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    FarNone   = 2'd0,
    FarObject = 2'd1,
    FarGlobal = 2'd2,
    FarScaled = 2'd3
  } far_mode_e;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pipe_en_t;

endpackage

// ----- rtl/core/dcci_far_scale.sv -----
`timescale 1ns / 1ps

module dcci_far_scale (
  input  logic                                    clk_i,
  input  logic                                    en_i,
  input  logic signed [dcci_pkg::FactorW-1:0]     global_factor_i,
  input  logic signed [dcci_pkg::FarW-1:0]        object_far_i,
  output logic signed [dcci_pkg::FarW-1:0]        object_far_o,
  output logic signed [dcci_pkg::FarW-1:0]        scaled_far_o
);

  logic signed [dcci_pkg::ScaleW-1:0] scale;
  logic signed [dcci_pkg::ProdW-1:0]  prod;
  logic signed [dcci_pkg::FarW-1:0]   object_far_q;
  logic signed [dcci_pkg::FarW-1:0]   scaled_far_q;
  logic signed [dcci_pkg::FarW-1:0]   scaled_far_d;

  assign scale = dcci_pkg::CueOne
               - dcci_pkg::ScaleW'(global_factor_i);
  assign prod  = dcci_pkg::ProdW'(scale) * dcci_pkg::ProdW'(object_far_i);
  // floor shift, keep low word
  assign scaled_far_d = prod[dcci_pkg::CueSh +: dcci_pkg::FarW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      object_far_q <= object_far_i;
      scaled_far_q <= scaled_far_d;
    end
  end

  assign object_far_o = object_far_q;
  assign scaled_far_o = scaled_far_q;

endmodule

// ----- rtl/core/dcci_chan.sv -----
`timescale 1ns / 1ps

module dcci_chan (
  input  logic                                    clk_i,
  input  dcci_pkg::pipe_en_t                      en_i,
  input  dcci_pkg::far_mode_e                     mode_i,
  input  logic signed [dcci_pkg::FactorW-1:0]     factor_i,
  input  logic [dcci_pkg::ChanW-1:0]              src_i,
  input  logic signed [dcci_pkg::FarW-1:0]        object_far_i,
  input  logic signed [dcci_pkg::FarW-1:0]        scaled_far_i,
  input  logic signed [dcci_pkg::FarW-1:0]        global_far_i,
  output logic [dcci_pkg::ChanW-1:0]              chan_o
);

  logic signed [dcci_pkg::FarW-1:0]      far_c;
  logic [dcci_pkg::SrcW-1:0]             s_d;
  logic signed [dcci_pkg::FarW:0]        diff_wide;
  logic signed [dcci_pkg::DiffW-1:0]     diff_d;

  logic [dcci_pkg::SrcW-1:0]             s2_q;
  logic signed [dcci_pkg::DiffW-1:0]     diff2_q;
  logic signed [dcci_pkg::FactorW-1:0]   factor2_q;

  logic [dcci_pkg::SrcW-1:0]             s3_q;
  logic signed [dcci_pkg::MulW-1:0]      mul3_d;
  logic signed [dcci_pkg::MulW-1:0]      mul3_q;

  logic signed [dcci_pkg::SumW-1:0]      sum;
  logic signed [dcci_pkg::SumW-dcci_pkg::FracW-1:0] sum_sh;
  logic [dcci_pkg::ChanW-1:0]            chan_d;
  logic [dcci_pkg::ChanW-1:0]            chan4_q;

  always_comb begin
    case (mode_i)
      dcci_pkg::FarNone:   far_c = '0;
      dcci_pkg::FarObject: far_c = object_far_i;
      dcci_pkg::FarGlobal: far_c = global_far_i;
      dcci_pkg::FarScaled: far_c = scaled_far_i;
      default:             far_c = '0;
    endcase
  end

  assign s_d       = {src_i, {dcci_pkg::FracW{1'b0}}};
  assign diff_wide = (dcci_pkg::FarW+1)'(far_c)
                   - $signed({{(dcci_pkg::FarW+1-dcci_pkg::SrcW){1'b0}}, s_d});

  always_comb begin
    if (diff_wide > (dcci_pkg::FarW+1)'(dcci_pkg::DiffMax)) begin
      diff_d = dcci_pkg::DiffMax;
    end else if (diff_wide < (dcci_pkg::FarW+1)'(dcci_pkg::DiffMin)) begin
      diff_d = dcci_pkg::DiffMin;
    end else begin
      diff_d = diff_wide[dcci_pkg::DiffW-1:0];
    end
  end

  assign mul3_d = dcci_pkg::MulW'(factor2_q) * dcci_pkg::MulW'(diff2_q);

  assign sum = $signed({{(dcci_pkg::SumW-dcci_pkg::SrcW){1'b0}}, s3_q})
             + dcci_pkg::SumW'($signed(mul3_q[dcci_pkg::MulW-1:dcci_pkg::CueSh]));
  assign sum_sh = sum[dcci_pkg::SumW-1:dcci_pkg::FracW];

  always_comb begin
    if (sum_sh[dcci_pkg::SumW-dcci_pkg::FracW-1]) begin
      chan_d = '0;
    end else if (sum_sh > (dcci_pkg::SumW-dcci_pkg::FracW)'(dcci_pkg::ChanMax)) begin
      chan_d = dcci_pkg::ChanMax;
    end else begin
      chan_d = sum_sh[dcci_pkg::ChanW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_q      <= s_d;
      diff2_q   <= diff_d;
      factor2_q <= factor_i;
    end
    if (en_i.s3) begin
      s3_q   <= s2_q;
      mul3_q <= mul3_d;
    end
    if (en_i.s4) begin
      chan4_q <= chan_d;
    end
  end

  assign chan_o = chan4_q;

endmodule

// ----- rtl/core/depth_cue_color_interpolator.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle unless m_axis_tready holds the output; the
// far-color scaling multiply, the difference clamp, the factor multiply and
// the final add/clamp each own a registered stage, s1 to s4, in that order.
// Reset clears all stage valid bits and the global cue registers to zero.
// Ready on the slave side stays high as long as any stage can advance.

module depth_cue_color_interpolator (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_addr_i,
  input  logic [31:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // source_color[31:0], object_cue_factor[47:32], object_far_red[79:48],
  // object_far_green[111:80], object_far_blue[143:112]
  input  logic [143:0]  s_axis_tdata,
  // object_cue_enable[0]
  input  logic          s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // cued_color[31:0]
  output logic [31:0]   m_axis_tdata
);

  localparam int unsigned NumCh = 3;

  logic signed [dcci_pkg::FactorW-1:0] g_factor_q;
  logic signed [dcci_pkg::FarW-1:0]    g_far_q [NumCh];

  dcci_pkg::pipe_en_t en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic [31:0]                         src;
  logic                                obj_on;
  logic signed [dcci_pkg::FactorW-1:0] obj_factor;
  logic signed [dcci_pkg::FarW-1:0]    obj_far [NumCh];

  dcci_pkg::far_mode_e                 mode_d, mode1_q;
  logic signed [dcci_pkg::FactorW-1:0] factor_d, factor1_q;
  logic [23:0]                         rgb1_q;
  logic [7:0]                          alpha1_q, alpha2_q, alpha3_q, alpha4_q;

  logic signed [dcci_pkg::FarW-1:0]    obj_far1 [NumCh];
  logic signed [dcci_pkg::FarW-1:0]    scaled_far1 [NumCh];
  logic [dcci_pkg::ChanW-1:0]          chan [NumCh];

  assign src        = s_axis_tdata[31:0];
  assign obj_on     = s_axis_tuser;
  assign obj_factor = s_axis_tdata[47:32];
  assign obj_far[0] = s_axis_tdata[79:48];
  assign obj_far[1] = s_axis_tdata[111:80];
  assign obj_far[2] = s_axis_tdata[143:112];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_factor_q <= '0;
      for (int i = 0; i < NumCh; i++) g_far_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (dcci_pkg::reg_idx_e'(cfg_addr_i))
        dcci_pkg::RegGlobalFactor: g_factor_q <= cfg_wdata_i[dcci_pkg::FactorW-1:0];
        dcci_pkg::RegGlobalRed:    g_far_q[0] <= cfg_wdata_i;
        dcci_pkg::RegGlobalGreen:  g_far_q[1] <= cfg_wdata_i;
        dcci_pkg::RegGlobalBlue:   g_far_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    en.s4 = !v4_q || m_axis_tready;
    en.s3 = !v3_q || en.s4;
    en.s2 = !v2_q || en.s3;
    en.s1 = !v1_q || en.s2;
  end

  assign s_axis_tready = en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en.s1) v1_q <= s_axis_tvalid;
      if (en.s2) v2_q <= v1_q;
      if (en.s3) v3_q <= v2_q;
      if (en.s4) v4_q <= v3_q;
    end
  end

  // pick effective factor and far color source
  always_comb begin
    if (g_factor_q == '0) begin
      mode_d   = obj_on ? dcci_pkg::FarObject : dcci_pkg::FarNone;
      factor_d = obj_on ? obj_factor : '0;
    end else begin
      mode_d   = obj_on ? dcci_pkg::FarScaled : dcci_pkg::FarGlobal;
      factor_d = g_factor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      mode1_q   <= mode_d;
      factor1_q <= factor_d;
      rgb1_q    <= src[23:0];
      alpha1_q  <= src[31:24];
    end
    if (en.s2) alpha2_q <= alpha1_q;
    if (en.s3) alpha3_q <= alpha2_q;
    if (en.s4) alpha4_q <= alpha3_q;
  end

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    dcci_far_scale u_scale (
      .clk_i           (clk_i),
      .en_i            (en.s1),
      .global_factor_i (g_factor_q),
      .object_far_i    (obj_far[c]),
      .object_far_o    (obj_far1[c]),
      .scaled_far_o    (scaled_far1[c])
    );

    dcci_chan u_chan (
      .clk_i        (clk_i),
      .en_i         (en),
      .mode_i       (mode1_q),
      .factor_i     (factor1_q),
      .src_i        (rgb1_q[8*c +: 8]),
      .object_far_i (obj_far1[c]),
      .scaled_far_i (scaled_far1[c]),
      .global_far_i (g_far_q[c]),
      .chan_o       (chan[c])
    );
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {alpha4_q, chan[2], chan[1], chan[0]};

endmodule

// ----- bench/tb_depth_cue_color_interpolator.sv -----
`timescale 1ns / 1ps

module tb_depth_cue_color_interpolator;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned NumPhases  = 12;
  localparam int unsigned PhaseItems = 84;
  localparam int unsigned NumRows    = 17;

  typedef struct {
    logic [15:0] gfac;
    logic [31:0] gred;
    logic [31:0] ggreen;
    logic [31:0] gblue;
    logic [31:0] src;
    logic        en;
    logic [15:0] ofac;
    logic [31:0] ored;
    logic [31:0] ogreen;
    logic [31:0] oblue;
    logic        has_exp;
    logic [31:0] exp_color;
  } stim_row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [1:0]    cfg_addr_i = '0;
  logic [31:0]   cfg_wdata_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [143:0]  s_axis_tdata = '0;
  logic          s_axis_tuser = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [31:0]   m_axis_tdata;

  logic signed [15:0] glob_factor = '0;
  logic signed [31:0] glob_far [3] = '{default: '0};
  logic [31:0]        cued_exp_q [$];
  int unsigned        mismatch_count = 0;
  int unsigned        cycle_count = 0;
  bit                 steady = 1'b0;

  stim_row_t dir_rows [NumRows] = '{
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'hA1B2C3D4, 1'b0, 16'h1234,
      32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b1, 32'hA1B2C3D4},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b1, 16'h0000,
      32'h12345678, 32'h80000000, 32'h7FFFFFFF, 1'b1, 32'hFFFFFFFF},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h80FFFFFF, 1'b1, 16'h1000,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h80000000},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h00000000, 1'b1, 16'h1000,
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 32'h00FFFFFF},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b1, 16'h1000,
      32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 32'hFF000000},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h00000000, 1'b1, 16'h7FFF,
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 32'h00FFFFFF},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h5A000000, 1'b1, 16'h8000,
      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, 32'h5A000000},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h00010101, 1'b1, 16'hFFFF,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h00010101},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h00010101, 1'b1, 16'h0001,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h00000000},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'h00000000, 1'b1, 16'h0800,
      32'h00000FF0, 32'h00000FF0, 32'h00000FF0, 1'b1, 32'h007F7F7F},
    '{16'h0000, 32'h0, 32'h0, 32'h0, 32'hC3804020, 1'b1, 16'h0C00,
      32'h00000200, 32'hFFFFF000, 32'h00010000, 1'b0, 32'h0},
    '{16'h1000, 32'h00000FF0, 32'h0, 32'h7FFFFFFF, 32'h11223344, 1'b0, 16'h0000,
      32'h0, 32'h0, 32'h0, 1'b1, 32'h11FF00FF},
    '{16'h1000, 32'h00000FF0, 32'h0, 32'h7FFFFFFF, 32'h11223344, 1'b1, 16'h7FFF,
      32'h7FFFFFFF, 32'h80000000, 32'h00001234, 1'b1, 32'h11000000},
    '{16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h00000800, 32'hFFFFFFFF, 1'b0, 16'h4000,
      32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
    '{16'h8000, 32'h80000000, 32'h7FFFFFFF, 32'h00000800, 32'h0000FF80, 1'b1, 16'h0123,
      32'h7FFFFFFF, 32'h80000000, 32'h00001000, 1'b0, 32'h0},
    '{16'h7FFF, 32'h00000FF0, 32'hFFFFFF00, 32'h12345678, 32'h89ABCDEF, 1'b1, 16'h0000,
      32'h80000000, 32'h7FFFFFFF, 32'hFFFF0000, 1'b0, 32'h0},
    '{16'hFFFF, 32'h00000100, 32'hFFFFFF00, 32'h00000F00, 32'h3C5A7896, 1'b1, 16'h0000,
      32'h00000A00, 32'hFFFFF800, 32'h00000FF0, 1'b0, 32'h0}
  };

  depth_cue_color_interpolator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] cue_chan(logic [7:0] b, longint farc, longint fac);
    longint s;
    longint d;
    longint v;
    s = longint'({b, 4'b0000});
    d = farc - s;
    if (d > longint'(dcci_pkg::DiffMax)) d = longint'(dcci_pkg::DiffMax);
    else if (d < longint'(dcci_pkg::DiffMin)) d = longint'(dcci_pkg::DiffMin);
    v = (s + ((fac * d) >>> dcci_pkg::CueSh)) >>> dcci_pkg::FracW;
    if (v < 0) v = 0;
    else if (v > longint'(dcci_pkg::ChanMax)) v = longint'(dcci_pkg::ChanMax);
    return v[7:0];
  endfunction

  function automatic logic [31:0] predict_cued(logic [31:0] src, logic en, logic [15:0] ofac,
                                               logic [31:0] ored, logic [31:0] ogreen,
                                               logic [31:0] oblue);
    longint fac;
    longint scale;
    longint ofar [3];
    longint farc [3];
    logic [7:0] ch [3];
    ofar[0] = longint'($signed(ored));
    ofar[1] = longint'($signed(ogreen));
    ofar[2] = longint'($signed(oblue));
    fac = 0;
    farc = '{default: 0};
    if (glob_factor == 0) begin
      if (en) begin
        fac = longint'($signed(ofac));
        farc = ofar;
      end
    end else begin
      fac = glob_factor;
      if (!en) begin
        for (int i = 0; i < 3; i++) farc[i] = glob_far[i];
      end else begin
        scale = longint'(dcci_pkg::CueOne) - fac;
        for (int i = 0; i < 3; i++)
          farc[i] = longint'(int'((scale * ofar[i]) >>> dcci_pkg::CueSh));
      end
    end
    for (int i = 0; i < 3; i++) ch[i] = cue_chan(src[8*i +: 8], farc[i], fac);
    return {src[31:24], ch[2], ch[1], ch[0]};
  endfunction

  function automatic logic [15:0] rand_factor();
    case ($urandom_range(0, 6))
      0: return 16'h0000;
      1: return 16'h7FFF;
      2: return 16'h8000;
      3: return 16'h1000;
      4: return 16'($urandom_range(0, 16'h1000));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_far();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h0FF0);
      3: return $urandom_range(0, 32'h2800) - 32'h1400;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_color();
    case ($urandom_range(0, 7))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (cued_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(dcci_pkg::reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
  endtask

  task automatic set_config(logic [15:0] fac, logic [31:0] fred, logic [31:0] fgreen,
                            logic [31:0] fblue);
    settle();
    write_reg(dcci_pkg::RegGlobalFactor, {16'($urandom), fac});
    write_reg(dcci_pkg::RegGlobalRed, fred);
    write_reg(dcci_pkg::RegGlobalGreen, fgreen);
    write_reg(dcci_pkg::RegGlobalBlue, fblue);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    glob_factor = fac;
    glob_far[0] = fred;
    glob_far[1] = fgreen;
    glob_far[2] = fblue;
  endtask

  task automatic send_item(logic [31:0] src, logic en, logic [15:0] ofac, logic [31:0] ored,
                           logic [31:0] ogreen, logic [31:0] oblue, logic has_exp,
                           logic [31:0] exp_color);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {oblue, ogreen, ored, ofac, src};
    s_axis_tuser  <= en;
    do @(posedge clk_i); while (!s_axis_tready);
    cued_exp_q.push_back(has_exp ? exp_color
                                 : predict_cued(src, en, ofac, ored, ogreen, oblue));
  endtask

  initial begin
    int stall;
    logic [31:0] want;
    wait (rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if (cued_exp_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected transfer: cued_color %h", m_axis_tdata);
      end else begin
        want = cued_exp_q.pop_front();
        if (m_axis_tdata !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("cued_color mismatch: expected %h got %h", want, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      row = dir_rows[r];
      if (row.gfac != glob_factor || row.gred != glob_far[0] || row.ggreen != glob_far[1] ||
          row.gblue != glob_far[2]) begin
        set_config(row.gfac, row.gred, row.ggreen, row.gblue);
      end
      send_item(row.src, row.en, row.ofac, row.ored, row.ogreen, row.oblue, row.has_exp,
                row.exp_color);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_config(16'h0000, rand_far(), rand_far(), rand_far());
        1: set_config(16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        2: set_config(16'h8000, 32'h80000000, 32'h80000000, 32'h80000000);
        3: set_config(16'h1000, $urandom_range(0, 32'h0FF0), $urandom_range(0, 32'h0FF0),
                      $urandom_range(0, 32'h0FF0));
        4: set_config(16'hFFFF, rand_far(), rand_far(), rand_far());
        5: set_config(16'h0001, rand_far(), rand_far(), rand_far());
        default: set_config(rand_factor(), rand_far(), rand_far(), rand_far());
      endcase
      steady = (ph % 4 == 3);
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 5 && n == PhaseItems / 2) settle();
        send_item(rand_color(), 1'($urandom_range(0, 1)), rand_factor(), rand_far(),
                  rand_far(), rand_far(), 1'b0, '0);
      end
    end
    steady = 1'b0;

    settle();
    if (mismatch_count == 0 && cued_exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/dcci_pkg.sv
rtl/core/dcci_far_scale.sv
rtl/core/dcci_chan.sv
rtl/core/depth_cue_color_interpolator.sv
bench/tb_depth_cue_color_interpolator.sv
